>>> hw/rtl/cre_pkg.sv
// Package for the CIGAR run-length encoder: types, op codes and sizes.
`default_nettype none

package cre_pkg;

  localparam int unsigned MaxReadLenDefault = 32'd65535;
  localparam int unsigned CountWidth        = 16;
  localparam int unsigned OpWidth           = 2;

  // result queue: up to two pushes per cycle, one pop
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueLvlW  = $clog2(QueueDepth + 1);

  typedef enum logic [OpWidth-1:0] {
    OpMatch = 2'd0,
    OpSoft  = 2'd1,
    OpDel   = 2'd2
  } cre_op_e;

  typedef struct packed {
    logic                  is_gap;
    logic [CountWidth-1:0] clip_left;
    logic [CountWidth-1:0] clip_right;
    logic                  read_last;
  } cre_item_t;

  typedef struct packed {
    logic [CountWidth-1:0] run_length;
    cre_op_e               op_code;
    logic                  end_of_read;
  } cre_res_t;

  // results of one item, packed to the front: res0 first, then res1
  typedef struct packed {
    logic [1:0] num;
    cre_res_t   res0;
    cre_res_t   res1;
  } cre_push_t;

  typedef struct packed {
    logic                 can_take;
    logic [QueueLvlW-1:0] level;
  } cre_qstat_t;

endpackage

`default_nettype wire

>>> hw/rtl/cre_if.sv
// Channel interfaces of the CIGAR run-length encoder.
`default_nettype none

interface cre_in_if;
  logic        valid;
  logic        ready;
  logic        is_gap;
  logic [15:0] clip_left;
  logic [15:0] clip_right;
  logic        read_last;

  modport source (output valid, is_gap, clip_left, clip_right, read_last, input ready);
  modport sink   (input valid, is_gap, clip_left, clip_right, read_last, output ready);
endinterface

interface cre_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_length;
  logic [1:0]  op_code;
  logic        end_of_read;

  modport source (output valid, run_length, op_code, end_of_read, input ready);
  modport sink   (input valid, run_length, op_code, end_of_read, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cigar_run_length_encoder.sv
// CIGAR run-length encoder: one padded base in, finished (length, op) runs out.
//
// Input channel in_i carries one padded base per transaction with its gap
// flag, the read's clip bounds and a last-base flag. Output channel out_o
// carries finished runs (run_length, op_code, end_of_read) in read order.
// Both channels use valid/ready; a transaction completes when both are high.
// Throughput: one base per cycle while in_i.ready is high. A base updates
// the run state in the cycle it is taken and writes zero, one or two runs
// into a four-entry queue, whose head drives out_o; the queue drains one run
// per cycle while out_o.ready is high. in_i.ready is high while at least two
// queue entries are free; it falls when bases with two runs each or a stalled
// receiver fill the queue past that point, and no run is ever dropped.
// Reset (rst_ni low, asynchronous) empties the queue and returns the run
// state to soft clip, zero length, position zero. The same per-read state is
// restored after every last base.
// Run lengths and positions saturate at min(MAX_READ_LEN, 65535).
`default_nettype none

module cigar_run_length_encoder
  import cre_pkg::*;
#(
  parameter int unsigned MAX_READ_LEN = MaxReadLenDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cre_in_if.sink    in_i,
  cre_out_if.source out_o
);

  cre_item_t  item;
  cre_push_t  push;
  cre_res_t   head;
  cre_qstat_t qstat;
  logic       in_acc;
  logic       out_vld;

  assign item = '{is_gap:     in_i.is_gap,
                  clip_left:  in_i.clip_left,
                  clip_right: in_i.clip_right,
                  read_last:  in_i.read_last};

  assign in_i.ready = qstat.can_take;
  assign in_acc     = in_i.valid && qstat.can_take;

  cre_step #(
    .MAX_READ_LEN(MAX_READ_LEN)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .item_i   (item),
    .push_o   (push)
  );

  cre_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (in_acc),
    .push_i    (push),
    .pop_i     (out_o.ready),
    .valid_o   (out_vld),
    .head_o    (head),
    .stat_o    (qstat)
  );

  assign out_o.valid       = out_vld;
  assign out_o.run_length  = head.run_length;
  assign out_o.op_code     = head.op_code;
  assign out_o.end_of_read = head.end_of_read;

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.level <= QueueLvlW'(QueueDepth))
    else $error("result queue level beyond depth");

  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.read_last |=> out_o.valid)
    else $error("last base produced no run");

  a_out_follows_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid == (qstat.level != '0))
    else $error("output valid disagrees with queue level");

endmodule

`default_nettype wire

>>> hw/rtl/cre_step.sv
// Per-read state and per-base run logic of the CIGAR run-length encoder.
`default_nettype none

module cre_step
  import cre_pkg::*;
#(
  parameter int unsigned MAX_READ_LEN = MaxReadLenDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire cre_item_t item_i,
  output cre_push_t      push_o
);

  localparam logic [CountWidth-1:0] CountCap =
      (MAX_READ_LEN > 32'd65535) ? 16'hFFFF : MAX_READ_LEN[CountWidth-1:0];

  cre_op_e               op_q, op_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] pos_q, pos_d;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v >= CountCap) ? CountCap : v + 1'b1;
  endfunction

  cre_op_e               op_n;
  logic [CountWidth-1:0] cnt_n;
  logic                  flush_v;
  cre_res_t              flush_r, last_r;

  always_comb begin
    op_n    = op_q;
    cnt_n   = cnt_q;
    flush_v = 1'b0;
    flush_r = '{run_length: cnt_q, op_code: op_q, end_of_read: 1'b0};

    if (item_i.is_gap) begin
      // gaps while the open run is a soft clip only move the position
      if (op_q != OpSoft) begin
        if (op_q != OpDel && cnt_q != '0) begin
          flush_v = 1'b1;
          cnt_n   = '0;
        end
        op_n  = OpDel;
        cnt_n = sat_inc(cnt_n);
      end
    end else if (pos_q < item_i.clip_left) begin
      if (op_q != OpSoft && cnt_q != '0) begin
        flush_v = 1'b1;
        cnt_n   = '0;
      end
      op_n  = OpSoft;
      cnt_n = sat_inc(cnt_n);
    end else if (pos_q < item_i.clip_right) begin
      if (op_q != OpMatch && cnt_q != '0) begin
        flush_v = 1'b1;
        cnt_n   = '0;
      end
      op_n  = OpMatch;
      cnt_n = sat_inc(cnt_n);
    end else begin
      // trailing clip swallows a pending deletion
      if (op_q != OpSoft && cnt_q != '0) begin
        flush_v = (op_q != OpDel);
        cnt_n   = '0;
      end
      op_n  = OpSoft;
      cnt_n = sat_inc(cnt_n);
    end

    last_r = '{run_length:  cnt_n,
               op_code:     (cnt_n != '0) ? op_n : OpSoft,
               end_of_read: 1'b1};

    push_o.num  = {1'b0, flush_v} + {1'b0, item_i.read_last};
    push_o.res0 = flush_v ? flush_r : last_r;
    push_o.res1 = last_r;

    if (item_i.read_last) begin
      op_d  = OpSoft;
      cnt_d = '0;
      pos_d = '0;
    end else begin
      op_d  = op_n;
      cnt_d = cnt_n;
      pos_d = sat_inc(pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OpSoft;
      cnt_q <= '0;
      pos_q <= '0;
    end else if (accept_i) begin
      op_q  <= op_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cre_queue.sv
// Result queue of the CIGAR run-length encoder: up to two pushes, one pop a cycle.
`default_nettype none

module cre_queue
  import cre_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_en_i,
  input  wire cre_push_t push_i,
  input  wire logic      pop_i,
  output logic           valid_o,
  output cre_res_t       head_o,
  output cre_qstat_t     stat_o
);

  cre_res_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QueueLvlW-1:0]  lvl_q, lvl_d;
  logic [1:0]            n_push;
  logic                  do_pop;
  logic [QueuePtrW-1:0]  wr_nxt;

  assign n_push  = push_en_i ? push_i.num : 2'd0;
  assign do_pop  = pop_i && (lvl_q != '0);
  assign wr_nxt  = wr_q + 1'b1;
  assign valid_o = (lvl_q != '0);
  assign head_o  = mem_q[rd_q];

  // room for the worst case of two results per transaction
  assign stat_o.can_take = (lvl_q <= QueueLvlW'(QueueDepth - 2));
  assign stat_o.level    = lvl_q;

  always_comb begin
    wr_d  = wr_q + QueuePtrW'(n_push);
    rd_d  = rd_q + QueuePtrW'(do_pop);
    lvl_d = lvl_q + QueueLvlW'(n_push) - QueueLvlW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= push_i.res0;
    if (n_push == 2'd2) mem_q[wr_nxt] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

`default_nettype wire

>>> test/cre_run_checker.sv
// Run checker for the CIGAR encoder: predicts runs per base and compares them.
`timescale 1ns / 100ps

module cre_run_checker
  import cre_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cre_in_if    base_i,
  cre_out_if   run_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [CountWidth-1:0] CountCap =
    (MaxReadLenDefault > 65535) ? 16'hFFFF : 16'(MaxReadLenDefault);

  // predicted encoder state
  cre_op_e               cur_op;
  logic [CountWidth-1:0] run_len;
  logic [CountWidth-1:0] base_pos;

  cre_res_t pending_runs[$];
  int       fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_runs.size();

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v >= CountCap) ? CountCap : v + 1'b1;
  endfunction

  task automatic push_run(input logic [CountWidth-1:0] len, input cre_op_e op,
                          input logic eor);
    cre_res_t r;
    r.run_length  = len;
    r.op_code     = op;
    r.end_of_read = eor;
    pending_runs.push_back(r);
  endtask

  // close the open run if the base needs another op; a deletion that runs
  // into the trailing clip is dropped instead of emitted
  task automatic switch_op(input cre_op_e op, input logic drop_del);
    if (cur_op != op && run_len != 0) begin
      if (!(drop_del && cur_op == OpDel))
        push_run(run_len, cur_op, 1'b0);
      run_len = '0;
    end
    cur_op  = op;
    run_len = sat_inc(run_len);
  endtask

  task automatic encode_base(input cre_item_t b);
    if (b.is_gap) begin
      // gaps while the open run is a soft clip only move the position
      if (cur_op != OpSoft)
        switch_op(OpDel, 1'b0);
    end else if (base_pos < b.clip_left) begin
      switch_op(OpSoft, 1'b0);
    end else if (base_pos < b.clip_right) begin
      switch_op(OpMatch, 1'b0);
    end else begin
      switch_op(OpSoft, 1'b1);
    end
    base_pos = sat_inc(base_pos);
    if (b.read_last) begin
      if (run_len != 0)
        push_run(run_len, cur_op, 1'b1);
      else
        push_run('0, OpSoft, 1'b1);
      cur_op   = OpSoft;
      run_len  = '0;
      base_pos = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cre_item_t b;
    cre_res_t  exp_run;
    if (!rst_ni) begin
      cur_op     = OpSoft;
      run_len    = '0;
      base_pos   = '0;
      fail_count = 0;
      pending_runs.delete();
    end else begin
      if (base_i.valid && base_i.ready) begin
        b.is_gap     = base_i.is_gap;
        b.clip_left  = base_i.clip_left;
        b.clip_right = base_i.clip_right;
        b.read_last  = base_i.read_last;
        encode_base(b);
      end
      if (run_i.valid && run_i.ready) begin
        if (pending_runs.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected run: len %0d op %0d eor %0d", $time,
                     run_i.run_length, run_i.op_code, run_i.end_of_read);
          fail_count++;
        end else begin
          exp_run = pending_runs.pop_front();
          if (run_i.run_length !== exp_run.run_length ||
              run_i.op_code !== exp_run.op_code ||
              run_i.end_of_read !== exp_run.end_of_read) begin
            if (fail_count < 10)
              $display({"%0t: run mismatch: expected len %0d op %0d eor %0d,",
                        " got len %0d op %0d eor %0d"},
                       $time, exp_run.run_length, exp_run.op_code,
                       exp_run.end_of_read, run_i.run_length, run_i.op_code,
                       run_i.end_of_read);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> test/cigar_run_length_encoder_tb.sv
// Testbench top for the CIGAR encoder: clock, reset, base stimulus and verdict.
`timescale 1ns / 100ps

module cigar_run_length_encoder_tb;
  import cre_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;

  int   random_bases = 0;
  int   since_drain  = 0;
  logic tx_calm      = 1'b0;
  int   rx_stall_left = 0;
  int   rx_calm_left  = 0;

  cre_in_if  in_ch ();
  cre_out_if out_ch ();

  cigar_run_length_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cre_run_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (in_ch),
    .run_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short pauses, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (rx_calm_left > 0) begin
      rx_calm_left <= rx_calm_left - 1;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      rx_calm_left <= $urandom_range(40, 250);
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      rx_stall_left <= idle_cycles() - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_base(input logic gap, input logic [15:0] left,
                           input logic [15:0] right, input logic last);
    int n;
    n = 0;
    if (!tx_calm && $urandom_range(0, 99) < 35)
      n = idle_cycles();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.is_gap     <= gap;
    in_ch.clip_left  <= left;
    in_ch.clip_right <= right;
    in_ch.read_last  <= last;
    in_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // hold the sender until every predicted run has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // one read; 'G' is a gap base, anything else a real base
  task automatic send_pattern(input string pat, input logic [15:0] left,
                              input logic [15:0] right);
    for (int i = 0; i < pat.len(); i++)
      send_base(pat[i] == "G", left, right, i == pat.len() - 1);
  endtask

  task automatic send_read();
    int          len;
    int          shape;
    int          gap_pct;
    int          r;
    logic [15:0] left;
    logic [15:0] right;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 20);
    else if (r < 95) len = $urandom_range(21, 120);
    else len = $urandom_range(121, 400);
    shape = $urandom_range(0, 99);
    if (shape < 55) begin
      left  = 16'($urandom_range(0, len / 2));
      right = 16'($urandom_range(left, len));
    end else if (shape < 65) begin
      left  = '0;
      right = 16'($urandom_range(len, 65535));
    end else if (shape < 75) begin
      right = 16'($urandom_range(0, len));
      left  = right + 16'($urandom_range(1, 5));
    end else begin
      left  = 16'($urandom);
      right = 16'($urandom);
    end
    gap_pct = ($urandom_range(0, 99) < 10) ? 100 : $urandom_range(0, 40);
    tx_calm = ($urandom_range(0, 99) < 20);
    for (int i = 0; i < len; i++) begin
      // bounds that move in mid-read
      if (shape >= 88) begin
        left  = 16'($urandom_range(0, len));
        right = 16'($urandom_range(0, len));
        if ($urandom_range(0, 7) == 0) left = 16'($urandom);
      end
      send_base($urandom_range(0, 99) < gap_pct, left, right, i == len - 1);
    end
    tx_calm = 1'b0;
    random_bases += len;
    since_drain  += len;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.is_gap     <= 1'b0;
    in_ch.clip_left  <= '0;
    in_ch.clip_right <= '0;
    in_ch.read_last  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pattern("GG", 16'd0, 16'd10);
    send_pattern("NNNGGNNN", 16'd2, 16'd6);
    send_pattern("NNGGN", 16'd0, 16'd2);
    send_pattern("NGNN", 16'd5, 16'd2);
    send_pattern("N", 16'hFFFF, 16'hFFFF);
    send_pattern("G", 16'd0, 16'd0);
    send_pattern("NN", 16'd0, 16'd1);
    send_pattern("NG", 16'd0, 16'd5);
    wait_drained();

    while (random_bases < 1300) begin
      send_read();
      if (since_drain >= 300) begin
        wait_drained();
        since_drain = 0;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cre_pkg.sv
hw/rtl/cre_if.sv
hw/rtl/cre_step.sv
hw/rtl/cre_queue.sv
hw/rtl/cigar_run_length_encoder.sv
test/cre_run_checker.sv
test/cigar_run_length_encoder_tb.sv
